FILE: sv/dsp2_pkg.sv
// ----------------------------------------------------------------------------
// dsp2_pkg
// Shared constants and types for the binary64 power-of-two scaler.
// ----------------------------------------------------------------------------
package dsp2_pkg;

  localparam int FracW = 52;
  localparam int ExpW  = 11;
  localparam int SumW  = 34;

  localparam logic [ExpW-1:0] ExpMax = 11'h7ff;
  localparam logic signed [SumW-1:0] ExpTop    = 34'sd2046;
  localparam logic signed [SumW-1:0] UflowLim  = -34'sd54;
  localparam logic signed [31:0]     SubCutoff = -32'sd50000;

  typedef struct packed {
    logic [63:0] x_bits;
    logic [31:0] scale_exp;
  } req_t;

  typedef struct packed {
    logic [63:0] result_bits;
  } rsp_t;

endpackage

FILE: sv/dsp2_if.sv
// ----------------------------------------------------------------------------
// dsp2_req_if / dsp2_rsp_if
// Valid/ready channels carrying requests and results.
// ----------------------------------------------------------------------------
interface dsp2_req_if;
  logic                valid;
  logic                ready;
  dsp2_pkg::req_t      data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dsp2_rsp_if;
  logic                valid;
  logic                ready;
  dsp2_pkg::rsp_t      data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/dsp2_core.sv
// ----------------------------------------------------------------------------
// dsp2_core
// Combinational scale of a binary64 pattern by 2^n.
// ----------------------------------------------------------------------------
module dsp2_core (
  input  logic [63:0] x_bits,
  input  logic [31:0] scale_exp,
  output logic [63:0] result_bits
);
  import dsp2_pkg::*;

  logic              sign;
  logic [FracW-1:0]  frac;
  logic [ExpW-1:0]   expo;
  logic [5:0]        lz;
  logic [FracW-1:0]  frac_n;
  logic signed [SumW-1:0] k;
  logic signed [SumW-1:0] sum;
  logic [52:0]       mant;
  logic [5:0]        sh;
  logic [52:0]       q;
  logic [53:0]       rem;
  logic [53:0]       half;
  logic [53:0]       lowmask;

  always_comb begin
    lz = 6'd0;
    for (int i = 0; i < FracW; i++) begin
      if (frac[i]) lz = 6'(FracW - 1 - i);
    end
  end

  always_comb begin
    sign    = x_bits[63];
    frac    = x_bits[FracW-1:0];
    expo    = x_bits[62:FracW];
    frac_n  = frac;
    k       = SumW'($signed({1'b0, expo}));
    if (expo == '0) begin
      // subnormal: leading one at bit 51-lz moves to hidden position
      frac_n = (frac << (lz + 6'd1));
      k      = -SumW'($signed({1'b0, lz}));
    end
    sum     = k + SumW'($signed(scale_exp));
    mant    = {1'b1, frac_n};
    sh      = 6'(1 - sum);
    q       = mant >> sh;
    // one bit wider than the mantissa so a 54-bit shift keeps its half point
    lowmask = (54'd1 << sh) - 54'd1;
    rem     = {1'b0, mant} & lowmask;
    half    = 54'd1 << (sh - 6'd1);

    if (expo == '0 && frac == '0) begin
      result_bits = x_bits;
    end else if (expo == '0 && $signed(scale_exp) < SubCutoff) begin
      result_bits = {sign, 63'd0};
    end else if (expo == ExpMax) begin
      result_bits = (frac != '0) ? (x_bits | 64'h0008_0000_0000_0000) : x_bits;
    end else if (sum > ExpTop) begin
      result_bits = {sign, ExpMax, 52'd0};
    end else if (sum > 0) begin
      result_bits = {sign, sum[ExpW-1:0], frac_n};
    end else if (sum <= UflowLim) begin
      result_bits = {sign, 63'd0};
    end else begin
      if (rem > half || (rem == half && q[0])) q = q + 53'd1;
      result_bits = {sign, 10'd0, q};
    end
  end
endmodule

FILE: sv/double_scale_by_power_of_two.sv
// ----------------------------------------------------------------------------
// double_scale_by_power_of_two
// Binary64 x * 2^n with round-to-nearest-even on underflow.
// ----------------------------------------------------------------------------
// One request per cycle, one result per request: the request is captured
// in an input register, the exponent adjust, normalize and subnormal
// rounding run in one combinational pass, and the result sits in an output
// register. Both stages advance whenever the stage ahead is empty or being
// drained, so full throughput holds under output back pressure only as
// long as the consumer keeps ready high.
module double_scale_by_power_of_two (
  input logic        clk,
  input logic        rst,
  dsp2_req_if.sink   req,
  dsp2_rsp_if.source rsp
);
  import dsp2_pkg::*;

  logic        in_valid;
  req_t        in_reg;
  logic        out_valid;
  logic [63:0] out_reg;
  logic [63:0] core_res;
  logic        out_adv;
  logic        in_adv;

  assign out_adv   = !out_valid || rsp.ready;
  assign in_adv    = !in_valid || out_adv;
  assign req.ready = in_adv;

  dsp2_core u_core (
    .x_bits     (in_reg.x_bits),
    .scale_exp  (in_reg.scale_exp),
    .result_bits(core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_adv)  in_valid  <= req.valid;
      if (out_adv) out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_adv && req.valid) in_reg <= req.data;
    if (out_adv && in_valid) out_reg <= core_res;
  end

  assign rsp.valid            = out_valid;
  assign rsp.data.result_bits = out_reg;

  // held result stays put while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !rsp.ready |=> out_valid && $stable(out_reg)) else $error("result moved");
  // a captured request is never dropped
  a_keep: assert property (@(posedge clk) disable iff (rst)
    in_valid && !out_adv |=> in_valid) else $error("request lost");
  // result appears the cycle after an advancing request
  a_flow: assert property (@(posedge clk) disable iff (rst)
    in_valid && out_adv |=> out_valid) else $error("result missing");
endmodule
